[hdl/ivcs_pkg.sv]
// package for the indexing valve cycle sequencer
// holds sizes, codes, shared types and the time saturation function
// no dependencies
package ivcs_pkg;

  localparam int VALVES    = 6;
  localparam int TIME_BITS = 16;
  localparam int NTIMES    = 6;
  localparam int IN_TIME_W = 16;
  localparam int POS_W     = 3;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 8;

  localparam logic [POS_W-1:0]     POS_LAST = POS_W'(VALVES - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [CFG_W-1:0] MIN_ON_RST     = 8'd10;
  localparam logic [CFG_W-1:0] OFF_SETTLE_RST = 8'd45;

  // configuration register indexes
  localparam logic CFG_MIN_ON     = 1'b0;
  localparam logic CFG_OFF_SETTLE = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STOP  = 2'd1,
    OP_CYCLE = 2'd2,
    OP_QUIT  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_ON_MIN   = 4'b0010,
    PH_ON_EXTRA = 4'b0100,
    PH_SETTLE   = 4'b1000
  } phase_t;

  typedef logic [NTIMES-1:0][IN_TIME_W-1:0] in_times_t;
  typedef logic [NTIMES-1:0][TIME_BITS-1:0] times_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_on;
    logic [CFG_W-1:0] off_settle;
  } cfg_t;

  typedef struct packed {
    logic             halted;
    logic             busy;
    logic [POS_W-1:0] outlet;
    logic             drive_on;
  } res_t;

  function automatic logic [TIME_BITS-1:0] sat_time(input logic [IN_TIME_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(TIME_MAX)) begin
      sat_time = TIME_MAX;
    end else begin
      sat_time = w[TIME_BITS-1:0];
    end
  endfunction

endpackage

[hdl/ivcs_cfg_regs.sv]
// configuration registers: minimum on time and off settle time
// depends on ivcs_pkg
module ivcs_cfg_regs import ivcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [CFG_W-1:0] min_on;
  logic [CFG_W-1:0] off_settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_on     <= MIN_ON_RST;
      off_settle <= OFF_SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ON:     min_on     <= cfg_data;
        CFG_OFF_SETTLE: off_settle <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.min_on     = min_on;
  assign cfg.off_settle = off_settle;

endmodule

[hdl/ivcs_core.sv]
// sequencer state and the per-item update: ticks, pending commands,
// homing, outlet opens and settle waits; depends on ivcs_pkg
module ivcs_core import ivcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  opcode_t   op,
  input  in_times_t times,
  input  cfg_t      cfg,
  output res_t      res
);

  logic [POS_W-1:0]     position, position_next;
  logic                 energized, energized_next;
  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] seconds_left, seconds_left_next;
  logic                 homing, homing_next;
  logic [CNT_W-1:0]     opens_done, opens_done_next;
  times_t               active_times, active_times_next;
  logic                 pending_valid, pending_valid_next;
  opcode_t              pending_kind, pending_kind_next;
  times_t               pending_times, pending_times_next;
  logic                 stopped, stopped_next;

  logic [TIME_BITS-1:0] min_on_t;
  logic [TIME_BITS-1:0] off_settle_t;
  logic [TIME_BITS-1:0] len;

  assign min_on_t     = TIME_BITS'(cfg.min_on);
  assign off_settle_t = TIME_BITS'(cfg.off_settle);
  assign len          = homing ? min_on_t : active_times[opens_done];

  always_comb begin
    position_next      = position;
    energized_next     = energized;
    phase_next         = phase;
    seconds_left_next  = seconds_left;
    homing_next        = homing;
    opens_done_next    = opens_done;
    active_times_next  = active_times;
    pending_valid_next = pending_valid;
    pending_kind_next  = pending_kind;
    pending_times_next = pending_times;
    stopped_next       = stopped;

    if (!stopped) begin
      if (op == OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (seconds_left > TIME_BITS'(1)) begin
            seconds_left_next = seconds_left - TIME_BITS'(1);
          end else begin
            seconds_left_next = '0;
            case (phase)
              PH_ON_MIN: begin
                if (len > min_on_t && !pending_valid) begin
                  phase_next        = PH_ON_EXTRA;
                  seconds_left_next = len - min_on_t;
                end else begin
                  position_next     = (position == POS_LAST) ? '0 : position + POS_W'(1);
                  energized_next    = 1'b0;
                  phase_next        = PH_SETTLE;
                  seconds_left_next = off_settle_t;
                end
              end
              PH_ON_EXTRA: begin
                position_next     = (position == POS_LAST) ? '0 : position + POS_W'(1);
                energized_next    = 1'b0;
                phase_next        = PH_SETTLE;
                seconds_left_next = off_settle_t;
              end
              PH_SETTLE: begin
                if (homing) begin
                  if (position == '0) begin
                    homing_next     = 1'b0;
                    opens_done_next = '0;
                  end
                  energized_next    = 1'b1;
                  phase_next        = PH_ON_MIN;
                  seconds_left_next = min_on_t;
                end else if (opens_done == CNT_W'(VALVES - 1)) begin
                  // last outlet done: the cycle is over
                  opens_done_next   = '0;
                  phase_next        = PH_IDLE;
                  seconds_left_next = '0;
                end else begin
                  opens_done_next   = opens_done + CNT_W'(1);
                  energized_next    = 1'b1;
                  phase_next        = PH_ON_MIN;
                  seconds_left_next = min_on_t;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        pending_valid_next = 1'b1;
        pending_kind_next  = op;
        if (op == OP_CYCLE) begin
          for (int i = 0; i < NTIMES; i++) begin
            pending_times_next[i] = sat_time(times[i]);
          end
        end
        // a new command cuts the extra on time short
        if (phase == PH_ON_EXTRA) begin
          position_next     = (position == POS_LAST) ? '0 : position + POS_W'(1);
          energized_next    = 1'b0;
          phase_next        = PH_SETTLE;
          seconds_left_next = off_settle_t;
        end
      end

      if (phase_next == PH_IDLE && pending_valid_next) begin
        pending_valid_next = 1'b0;
        if (pending_kind_next == OP_QUIT) begin
          stopped_next = 1'b1;
        end else if (pending_kind_next == OP_CYCLE) begin
          active_times_next = pending_times_next;
          homing_next       = (position_next != '0);
          opens_done_next   = '0;
          energized_next    = 1'b1;
          phase_next        = PH_ON_MIN;
          seconds_left_next = min_on_t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      energized     <= 1'b0;
      phase         <= PH_IDLE;
      seconds_left  <= '0;
      homing        <= 1'b0;
      opens_done    <= '0;
      pending_valid <= 1'b0;
      pending_kind  <= OP_TICK;
      stopped       <= 1'b0;
    end else if (step) begin
      position      <= position_next;
      energized     <= energized_next;
      phase         <= phase_next;
      seconds_left  <= seconds_left_next;
      homing        <= homing_next;
      opens_done    <= opens_done_next;
      pending_valid <= pending_valid_next;
      pending_kind  <= pending_kind_next;
      stopped       <= stopped_next;
    end
  end

  // time tables are only read after an OP_CYCLE command has written them
  always_ff @(posedge clk) begin
    if (step) begin
      active_times  <= active_times_next;
      pending_times <= pending_times_next;
    end
  end

  assign res.halted   = stopped_next;
  assign res.busy     = (phase_next != PH_IDLE);
  assign res.outlet   = position_next;
  assign res.drive_on = energized_next;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halted flag cleared");

  a_drive_in_on_phase: assert property (@(posedge clk) disable iff (rst)
    energized |-> (phase == PH_ON_MIN || phase == PH_ON_EXTRA))
    else $error("drive on outside an on phase");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_LAST)
    else $error("position out of range");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !pending_valid)
    else $error("pending command left while idle");
`endif

endmodule

[hdl/indexing_valve_cycle_sequencer_top.sv]
// an item passes the input register, then the result register, before it can transfer
// out; one item per cycle while m_tready does not hold the result register
// the result register refills in the cycle it is taken, so no stall bubbles
// reset: synchronous rst clears the control state (not the data and time table registers),
// sets min on to 10 s and settle to 45 s; no clearing pass, items are taken right after reset
module indexing_valve_cycle_sequencer_top import ivcs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // valve_time_0 .. valve_time_5, 16 bits each from the lowest bit up
  input  logic [NTIMES*IN_TIME_W-1:0]   s_tdata,
  // opcode
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // drive_on, outlet[2:0], busy_res, halted, two zero bits
  output logic [7:0]                    m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  logic                        in_valid;
  logic [NTIMES*IN_TIME_W-1:0] in_data;
  opcode_t                     in_op;
  logic                        advance;
  logic                        out_valid;
  res_t                        out_res;
  res_t                        core_res;
  cfg_t                        cfg;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_op   <= opcode_t'(s_tuser);
    end
  end

  ivcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ivcs_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .op    (in_op),
    .times (in_times_t'(in_data)),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.halted, out_res.busy, out_res.outlet, out_res.drive_on};

endmodule

[sim/tb.sv]
// testbench for indexing_valve_cycle_sequencer_top: tick and command stream in,
// valve status stream out, checked against an in-bench model of the sequencer
// depends on hdl/ivcs_pkg.sv and hdl/indexing_valve_cycle_sequencer_top.sv
module tb import ivcs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_TAIL  = 8;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [NTIMES*IN_TIME_W-1:0] s_tdata = '0;
  logic [1:0]                  s_tuser = OP_TICK;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [7:0]                  m_tdata;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = CFG_MIN_ON;
  logic [CFG_W-1:0]            cfg_data = '0;

  indexing_valve_cycle_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 11;
  int recv_idle_pct = 48;
  int err_count     = 0;
  int res_count     = 0;
  int cycle_count   = 0;

  // valve model state
  logic [CFG_W-1:0]     cfg_min_on  = MIN_ON_RST;
  logic [CFG_W-1:0]     cfg_settle  = OFF_SETTLE_RST;
  logic [POS_W-1:0]     vs_pos      = '0;
  logic                 vs_drive    = 1'b0;
  phase_t               vs_phase    = PH_IDLE;
  logic [TIME_BITS-1:0] vs_left     = '0;
  logic                 vs_homing   = 1'b0;
  logic [CNT_W-1:0]     vs_opens    = '0;
  times_t               vs_times    = '0;
  logic                 vs_pend     = 1'b0;
  opcode_t              vs_pend_op  = OP_TICK;
  times_t               vs_pend_times = '0;
  logic                 vs_halted   = 1'b0;

  res_t expected_status[$];
  res_t want;
  res_t got;

  function automatic void start_pulse();
    vs_drive = 1'b1;
    vs_phase = PH_ON_MIN;
    vs_left  = TIME_BITS'(cfg_min_on);
  endfunction

  // drive off steps the valve to the next outlet
  function automatic void end_pulse();
    vs_pos   = (vs_pos == POS_LAST) ? '0 : vs_pos + POS_W'(1);
    vs_drive = 1'b0;
    vs_phase = PH_SETTLE;
    vs_left  = TIME_BITS'(cfg_settle);
  endfunction

  function automatic logic [TIME_BITS-1:0] open_length();
    if (vs_homing) return TIME_BITS'(cfg_min_on);
    if (vs_opens < NTIMES) return vs_times[vs_opens];
    return '0;
  endfunction

  function automatic void settle_done();
    if (vs_homing) begin
      if (vs_pos == '0) begin
        vs_homing = 1'b0;
        vs_opens  = '0;
      end
      start_pulse();
    end else begin
      vs_opens = vs_opens + CNT_W'(1);
      if (vs_opens >= VALVES) begin
        vs_opens = '0;
        vs_phase = PH_IDLE;
        vs_left  = '0;
      end else begin
        start_pulse();
      end
    end
  endfunction

  function automatic void take_command();
    vs_pend = 1'b0;
    if (vs_pend_op == OP_QUIT) begin
      vs_halted = 1'b1;
    end else if (vs_pend_op == OP_CYCLE) begin
      vs_times  = vs_pend_times;
      vs_homing = (vs_pos != '0);
      vs_opens  = '0;
      start_pulse();
    end
  endfunction

  function automatic void count_second();
    logic [TIME_BITS-1:0] len;
    if (vs_phase == PH_IDLE) return;
    if (vs_left > 1) begin
      vs_left = vs_left - TIME_BITS'(1);
      return;
    end
    vs_left = '0;
    if (vs_phase == PH_ON_MIN) begin
      len = open_length();
      if (len > TIME_BITS'(cfg_min_on) && !vs_pend) begin
        vs_phase = PH_ON_EXTRA;
        vs_left  = len - TIME_BITS'(cfg_min_on);
      end else begin
        end_pulse();
      end
    end else if (vs_phase == PH_ON_EXTRA) begin
      end_pulse();
    end else begin
      settle_done();
    end
  endfunction

  function automatic void advance_valve(opcode_t op, in_times_t t);
    res_t r;
    if (!vs_halted) begin
      if (op == OP_TICK) begin
        count_second();
      end else begin
        vs_pend    = 1'b1;
        vs_pend_op = op;
        if (op == OP_CYCLE) begin
          for (int i = 0; i < NTIMES; i++) begin
            vs_pend_times[i] = (32'(t[i]) > 32'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(t[i]);
          end
        end
        // a new command cuts the extra on time right away
        if (vs_phase == PH_ON_EXTRA) end_pulse();
      end
      if (vs_phase == PH_IDLE && vs_pend) take_command();
    end
    r.drive_on = vs_drive;
    r.outlet   = vs_pos;
    r.busy     = (vs_phase != PH_IDLE);
    r.halted   = vs_halted;
    expected_status = {expected_status, r};
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH %s at result %0d: got %0d expected %0d",
             what, res_count, got_v, want_v);
    err_count++;
  endtask

  function automatic in_times_t rand_times();
    in_times_t t;
    for (int i = 0; i < NTIMES; i++) begin
      t[i] = ($urandom_range(7) == 0) ? IN_TIME_W'($urandom) : IN_TIME_W'($urandom_range(6));
    end
    return t;
  endfunction

  function automatic in_times_t full_rand_times();
    in_times_t t;
    for (int i = 0; i < NTIMES; i++) t[i] = IN_TIME_W'($urandom);
    return t;
  endfunction

  task automatic send_item(input opcode_t op, input in_times_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_valve(op, t);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] min_on, input logic [CFG_W-1:0] settle);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_ON;
    cfg_data  <= min_on;
    @(posedge clk);
    cfg_index <= CFG_OFF_SETTLE;
    cfg_data  <= settle;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_min_on = min_on;
    cfg_settle = settle;
  endtask

  task automatic send_random(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 88) send_item(OP_TICK, rand_times());
      else if (r < 92) send_item(OP_STOP, rand_times());
      else send_item(OP_CYCLE, rand_times());
    end
  endtask

  // reset register values, a cycle taken at outlet 0, entry into extra on time
  task automatic test_reset_values();
    in_times_t t;
    t[0] = 16'hFFFF;
    t[1] = 16'h0000;
    t[2] = 16'h8000;
    t[3] = 16'h0001;
    t[4] = 16'h7FFF;
    t[5] = 16'h5555;
    send_item(OP_TICK, full_rand_times());
    send_item(OP_STOP, full_rand_times());
    send_item(OP_CYCLE, t);
    repeat (10) send_item(OP_TICK, ~t);
  endtask

  // zero durations last one second; times above the zero minimum go on
  // into extra on time
  task automatic test_zero_durations();
    in_times_t t;
    set_config(8'd0, 8'd0);
    t[0] = 16'd2;
    t[1] = 16'd0;
    t[2] = 16'd1;
    t[3] = 16'd0;
    t[4] = 16'd3;
    t[5] = 16'd0;
    send_item(OP_CYCLE, t);
    repeat (12) send_item(OP_TICK, full_rand_times());
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 11;
    recv_idle_pct = 48;
    set_config(8'd1, 8'd1);
    send_random(300);
    send_idle_pct = 48;
    recv_idle_pct = 11;
    set_config(8'd255, 8'd255);
    send_random(150);
    set_config(8'd3, 8'd2);
    send_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(8'd0, 8'd1);
    send_random(150);
    set_config(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)));
    send_random(150);
  endtask

  // quit waits for idle, then everything is ignored
  task automatic test_quit_halt();
    int guard;
    guard = 0;
    set_config(8'd1, 8'd2);
    send_item(OP_QUIT, full_rand_times());
    while (!vs_halted && guard < 4000) begin
      send_item(OP_TICK, full_rand_times());
      guard++;
    end
    repeat (16) send_item(opcode_t'($urandom_range(3)), full_rand_times());
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[5:0];
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected transfer", int'(m_tdata), 0);
      end else begin
        want = expected_status.pop_front();
        if (got.drive_on != want.drive_on)
          report_mismatch("drive_on", int'(got.drive_on), int'(want.drive_on));
        if (got.outlet != want.outlet)
          report_mismatch("outlet", int'(got.outlet), int'(want.outlet));
        if (got.busy != want.busy)
          report_mismatch("busy_res", int'(got.busy), int'(want.busy));
        if (got.halted != want.halted)
          report_mismatch("halted", int'(got.halted), int'(want.halted));
        if (m_tdata[7:6] != 2'b00) report_mismatch("pad bits", int'(m_tdata[7:6]), 0);
      end
      res_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_zero_durations();
    test_random_traffic();
    test_quit_halt();
    wait_drained();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ivcs_pkg.sv
hdl/ivcs_cfg_regs.sv
hdl/ivcs_core.sv
hdl/indexing_valve_cycle_sequencer_top.sv
sim/tb.sv
